/* rtl/chs_pkg.sv */
// ----------------------------------------------------------------------------
// Chained hash set package
// Shared constants and helpers for the chained hash set engine.
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam int BUCKET_BITS_DEF  = 8;
    localparam int POOL_ENTRIES_DEF = 256;
    localparam int KEY_BITS_DEF     = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // Hash mixing: (h<<7) - h + (h>>9) + (h>>17), modulo 2^32.
    function automatic logic [31:0] mix_hash(input logic [31:0] h);
        mix_hash = (h << 7) - h + (h >> 9) + (h >> 17);
    endfunction

endpackage

/* rtl/chs_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/chained_hash_set_engine.sv */
// ----------------------------------------------------------------------------
// Chained hash set engine
// Hash set over a pool of entries with one linked chain per bucket.
// ----------------------------------------------------------------------------
//  Channel  Direction  Fields (tdata from bit 0 up)
//  s_axis   in         op[1:0], key[33:2], hash_in[65:34] (72-bit tdata)
//  m_axis   out        done_res[0], pool_full[1], count[10:2] (16-bit tdata)
//
// An item other than a NOP walks S_HEAD and S_HWT, then S_ERD and S_ECMP per
// chain entry visited (an empty bucket goes from S_HWT straight to S_ECMP).
// A new insertion adds S_INS, after S_FRD and S_FWT when the entry comes from
// the free list; a removal adds S_REM, and S_RLK for a non-head entry, since
// the single link memory write port relinks the predecessor separately.
// After reset the bucket head memory is swept to null, one bucket a cycle,
// across all 2^BUCKET_BITS buckets, before the first item is accepted.
// s_axis_tready is low from acceptance until the result has been taken, so a
// stalled m_axis side simply holds the result.
// ----------------------------------------------------------------------------
module chained_hash_set_engine #(
    parameter int BUCKET_BITS  = chs_pkg::BUCKET_BITS_DEF,
    parameter int POOL_ENTRIES = chs_pkg::POOL_ENTRIES_DEF,
    parameter int KEY_BITS     = chs_pkg::KEY_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // op[1:0], key[33:2], hash_in[65:34], zeros
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // done_res[0], pool_full[1], count[10:2], zeros
);
    import chs_pkg::*;

    localparam int NB = 1 << BUCKET_BITS;
    localparam int IW = $clog2(POOL_ENTRIES + 1);   // index with room for null
    localparam int AW = $clog2(POOL_ENTRIES);
    localparam logic [IW-1:0] NIL = IW'(POOL_ENTRIES);

    // State codes.
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_HEAD = 4'd2;  // head read issued
    localparam logic [3:0] S_HWT  = 4'd3;  // head data available
    localparam logic [3:0] S_ERD  = 4'd4;  // entry read issued
    localparam logic [3:0] S_ECMP = 4'd5;  // entry data available, compare
    localparam logic [3:0] S_FRD  = 4'd6;  // free head link read
    localparam logic [3:0] S_FWT  = 4'd7;
    localparam logic [3:0] S_INS  = 4'd8;
    localparam logic [3:0] S_REM  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;
    localparam logic [3:0] S_RLK  = 4'd11; // predecessor relink

    logic [3:0]          r_state;
    logic [BUCKET_BITS-1:0] r_bkt;
    logic [1:0]          r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [IW-1:0]       r_head, r_cur, r_prev, r_hit, r_nxt, r_free, r_unused, r_new;
    logic [IW:0]         r_steps;
    logic [8:0]          r_count;
    logic                r_done, r_full;

    // Memories: bucket heads, entry keys, entry links.
    logic                   hd_we;
    logic [BUCKET_BITS-1:0] hd_wa;
    logic [IW-1:0]          hd_wd, hd_rd;
    logic                   ky_we;
    logic [AW-1:0]          ky_wa, en_ra;
    logic [KEY_BITS-1:0]    ky_rd;
    logic                   ln_we;
    logic [AW-1:0]          ln_wa;
    logic [IW-1:0]          ln_wd, ln_rd;

    chs_ram #(.WIDTH(IW), .DEPTH(NB)) u_heads (
        .i_clk, .i_we(hd_we), .i_waddr(hd_wa), .i_wdata(hd_wd),
        .i_raddr(r_bkt), .o_rdata(hd_rd));
    chs_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_ENTRIES)) u_keys (
        .i_clk, .i_we(ky_we), .i_waddr(ky_wa), .i_wdata(r_key),
        .i_raddr(en_ra), .o_rdata(ky_rd));
    chs_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_links (
        .i_clk, .i_we(ln_we), .i_waddr(ln_wa), .i_wdata(ln_wd),
        .i_raddr(en_ra), .o_rdata(ln_rd));

    logic [31:0] in_mix;
    assign in_mix = mix_hash(s_axis_tdata[65:34]);

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, r_count, r_full, r_done};

    // Entry read address: the chain cursor, or the free head when allocating.
    assign en_ra = (r_state == S_FRD) ? r_free[AW-1:0] : r_cur[AW-1:0];

    // Write ports are driven from the current state.
    always_comb begin
        hd_we = 1'b0; hd_wa = r_bkt; hd_wd = NIL;
        ky_we = 1'b0; ky_wa = r_new[AW-1:0];
        ln_we = 1'b0; ln_wa = r_new[AW-1:0]; ln_wd = r_head;
        case (r_state)
            S_CLR: begin
                hd_we = 1'b1;
            end
            S_INS: begin
                hd_we = 1'b1; hd_wd = r_new;
                ky_we = 1'b1;
                ln_we = 1'b1;
            end
            S_REM: begin
                // Push the hit on the free list; a head hit also moves the
                // bucket head on in the same cycle.
                if (r_prev == NIL) begin
                    hd_we = 1'b1; hd_wd = r_nxt;
                end
                ln_we = 1'b1; ln_wa = r_hit[AW-1:0]; ln_wd = r_free;
            end
            S_RLK: begin
                // The predecessor now skips the removed entry.
                ln_we = 1'b1; ln_wa = r_prev[AW-1:0]; ln_wd = r_nxt;
            end
            default: ;
        endcase
    end

    logic key_eq;
    assign key_eq = (ky_rd == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_bkt    <= '0;
            r_free   <= NIL;
            r_unused <= '0;
            r_count  <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_bkt <= r_bkt + 1'b1;
                    if (r_bkt == BUCKET_BITS'(NB - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op   <= s_axis_tdata[1:0];
                        r_key  <= s_axis_tdata[KEY_BITS+1:2];
                        r_bkt  <= in_mix[BUCKET_BITS-1:0];
                        r_done <= 1'b0;
                        r_full <= 1'b0;
                        r_state <= (s_axis_tdata[1:0] == OP_NOP) ? S_OUT : S_HEAD;
                    end
                end
                S_HEAD: r_state <= S_HWT;
                S_HWT: begin
                    r_head  <= hd_rd;
                    r_cur   <= hd_rd;
                    r_prev  <= NIL;
                    r_steps <= '0;
                    r_hit   <= NIL;
                    r_state <= (hd_rd < NIL) ? S_ERD : S_ECMP;
                end
                S_ERD: r_state <= S_ECMP;
                S_ECMP: begin
                    // Reached here with r_cur null means the walk ended.
                    if (r_cur < NIL && key_eq) begin
                        r_hit <= r_cur;
                        r_nxt <= ln_rd;
                        if (r_op == OP_REMOVE) r_state <= S_REM;
                        else begin
                            r_done  <= (r_op == OP_QUERY);
                            r_state <= S_OUT;
                        end
                    end else if (r_cur < NIL &&
                                 (r_steps + 1'b1) < (IW+1)'(POOL_ENTRIES) &&
                                 ln_rd < NIL) begin
                        r_prev  <= r_cur;
                        r_cur   <= ln_rd;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_ERD;
                    end else begin
                        // Absent.
                        if (r_op == OP_INSERT) begin
                            if (r_free < NIL) r_state <= S_FRD;
                            else if (r_unused < NIL) begin
                                r_new    <= r_unused;
                                r_unused <= r_unused + 1'b1;
                                r_state  <= S_INS;
                            end else begin
                                r_full  <= 1'b1;
                                r_state <= S_OUT;
                            end
                        end else r_state <= S_OUT;
                    end
                end
                S_FRD: r_state <= S_FWT;
                S_FWT: begin
                    r_new   <= r_free;
                    r_free  <= ln_rd;
                    r_state <= S_INS;
                end
                S_INS: begin
                    r_count <= r_count + 1'b1;
                    r_done  <= 1'b1;
                    r_state <= S_OUT;
                end
                S_REM: begin
                    r_free  <= r_hit;
                    if (r_count != 9'd0) r_count <= r_count - 1'b1;
                    r_done  <= 1'b1;
                    // A non-head hit still needs its predecessor relinked.
                    r_state <= (r_prev != NIL) ? S_RLK : S_OUT;
                end
                S_RLK: r_state <= S_OUT;
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Assertions.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while result held");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 9'(POOL_ENTRIES)) else $error("count beyond pool");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
